[hdl/nmd_pkg.sv]
// ----------------------------------------------------------------------------
// Netstring deframer package
// Shared constants and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package nmd_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 16;

	localparam logic [7:0] COLON_CHAR = 8'h3A;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] DIGIT_NINE = 8'h39;

	localparam logic FIELD_COMMAND = 1'b0;
	localparam logic FIELD_PAYLOAD = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       field_select;
		logic       has_data;
		logic       field_end;
		logic       truncated;
		logic       format_error;
	} result_t;

endpackage

`default_nettype wire

[hdl/nmd_in_reg.sv]
// ----------------------------------------------------------------------------
// Netstring deframer input register
// Captures one incoming byte and its end mark; holds it until the parser
// advances.
// ----------------------------------------------------------------------------
`default_nettype none

module nmd_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       message_end,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1,
	output logic            last_s1
);

	logic load;

	// take a new word when the register is empty or is being drained
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= in_byte;
			last_s1 <= message_end;
		end
	end

endmodule

`default_nettype wire

[hdl/nmd_parser.sv]
// ----------------------------------------------------------------------------
// Netstring deframer parser
// Phase tracking, length accumulation and per-byte result decode.
// ----------------------------------------------------------------------------
`default_nettype none

module nmd_parser import nmd_pkg::*; #(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] byte_s1,
	input  wire logic       last_s1,
	output logic            res_valid,
	output result_t         res
);

	localparam logic [2:0] PH_CMD_LEN  = 3'd0;
	localparam logic [2:0] PH_CMD_DATA = 3'd1;
	localparam logic [2:0] PH_SEP      = 3'd2;
	localparam logic [2:0] PH_PAY_LEN  = 3'd3;
	localparam logic [2:0] PH_PAY_DATA = 3'd4;
	localparam logic [2:0] PH_TRAILER  = 3'd5;
	localparam logic [2:0] PH_DROP     = 3'd6;

	logic [2:0]             phase_q, phase_d;
	logic [LENGTH_BITS-1:0] acc_q, acc_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic                   seen_q, seen_d;

	logic                   is_digit;
	logic [3:0]             digit;
	logic [LENGTH_BITS+3:0] acc_ext;
	logic [LENGTH_BITS+3:0] acc_next;
	logic                   ovf;
	logic                   fld;
	logic                   err;
	logic [LENGTH_BITS-1:0] rem_dec;
	logic                   done;

	assign is_digit = (byte_s1 >= DIGIT_ZERO) && (byte_s1 <= DIGIT_NINE);
	assign digit    = 4'(byte_s1 - DIGIT_ZERO);
	assign acc_ext  = {4'd0, acc_q};
	// times ten plus the digit; any bit above the length width is overflow
	assign acc_next = (acc_ext << 3) + (acc_ext << 1) + {{LENGTH_BITS{1'b0}}, digit};
	assign ovf      = |acc_next[LENGTH_BITS+3:LENGTH_BITS];
	assign rem_dec  = (rem_q == '0) ? '0 : rem_q - 1'b1;
	assign done     = (rem_dec == '0);

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		rem_d     = rem_q;
		seen_d    = seen_q;
		res_valid = 1'b0;
		res       = '0;
		err       = 1'b0;
		fld       = (phase_q == PH_PAY_LEN) || (phase_q == PH_PAY_DATA);

		case (phase_q)
			PH_CMD_LEN, PH_PAY_LEN: begin
				if (is_digit) begin
					if (ovf) begin
						err = 1'b1;
					end else begin
						acc_d  = acc_next[LENGTH_BITS-1:0];
						seen_d = 1'b1;
						err    = last_s1;
					end
				end else if (byte_s1 == COLON_CHAR && seen_q) begin
					acc_d  = '0;
					seen_d = 1'b0;
					if (!fld) begin
						if (last_s1) begin
							res_valid          = 1'b1;
							res.field_select   = FIELD_PAYLOAD;
							res.format_error   = 1'b1;
						end else if (acc_q == '0) begin
							res_valid          = 1'b1;
							res.field_select   = FIELD_COMMAND;
							res.field_end      = 1'b1;
							phase_d            = PH_SEP;
						end else begin
							rem_d   = acc_q;
							phase_d = PH_CMD_DATA;
						end
					end else begin
						if (acc_q == '0 || last_s1) begin
							res_valid          = 1'b1;
							res.field_select   = FIELD_PAYLOAD;
							res.field_end      = 1'b1;
							res.truncated      = (acc_q != '0);
							phase_d            = PH_TRAILER;
						end else begin
							rem_d   = acc_q;
							phase_d = PH_PAY_DATA;
						end
					end
				end else begin
					err = 1'b1;
				end
				if (err) begin
					res_valid        = 1'b1;
					res.field_select = fld;
					res.format_error = 1'b1;
					acc_d            = '0;
					seen_d           = 1'b0;
					phase_d          = PH_DROP;
				end
			end
			PH_CMD_DATA, PH_PAY_DATA: begin
				rem_d            = rem_dec;
				res_valid        = 1'b1;
				res.data_byte    = byte_s1;
				res.field_select = fld;
				res.has_data     = 1'b1;
				res.field_end    = done || last_s1;
				res.truncated    = last_s1 && !done;
				res.format_error = last_s1 && !fld;
				if (done) begin
					phase_d = fld ? PH_TRAILER : PH_SEP;
				end
			end
			PH_SEP: begin
				// skip the separator whatever its value
				if (last_s1) begin
					res_valid        = 1'b1;
					res.field_select = FIELD_PAYLOAD;
					res.format_error = 1'b1;
				end
				phase_d = PH_PAY_LEN;
			end
			default: begin
			end
		endcase

		// message end always restarts at the command length
		if (last_s1) begin
			phase_d = PH_CMD_LEN;
			acc_d   = '0;
			rem_d   = '0;
			seen_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD_LEN;
			acc_q   <= '0;
			rem_q   <= '0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			rem_q   <= rem_d;
			seen_q  <= seen_d;
		end
	end

endmodule

`default_nettype wire

[hdl/nmd_out_reg.sv]
// ----------------------------------------------------------------------------
// Netstring deframer result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nmd_out_reg import nmd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res,
	output logic         free,
	output logic         out_valid,
	input  wire logic    out_stall,
	output result_t      res_q
);

	// room when empty or when the held word leaves this cycle
	assign free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

[hdl/netstring_message_deframer_unit.sv]
// One byte of a serialized message is taken per clock. Each byte gives at most
// one result, held first in the input register and then in the result register,
// with the phase decode, length accumulation and field count in between. A new
// byte is accepted every cycle as long as the result register is not held by
// out_stall; bytes that produce no result (separator, trailer, dropped bytes,
// length digits) still advance at that rate.
// ----------------------------------------------------------------------------
// Netstring message deframer
// Splits a length-prefixed command and payload out of a byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

module netstring_message_deframer_unit import nmd_pkg::*; #(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       message_end,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      data_byte,
	output logic            field_select,
	output logic            has_data,
	output logic            field_end,
	output logic            truncated,
	output logic            format_error
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       free;
	logic       res_valid;
	result_t    res;
	result_t    res_q;

	assign advance = valid_s1 && free;

	nmd_in_reg u_in_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.message_end (message_end),
		.advance     (advance),
		.valid_s1    (valid_s1),
		.byte_s1     (byte_s1),
		.last_s1     (last_s1)
	);

	nmd_parser #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.byte_s1   (byte_s1),
		.last_s1   (last_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	nmd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign data_byte    = res_q.data_byte;
	assign field_select = res_q.field_select;
	assign has_data     = res_q.has_data;
	assign field_end    = res_q.field_end;
	assign truncated    = res_q.truncated;
	assign format_error = res_q.format_error;

endmodule

`default_nettype wire

[verif/deframer_result_checker.sv]
// ----------------------------------------------------------------------------
// Deframer result checker
// Watches both channels of the netstring deframer, predicts the result word, if any,
// for each accepted byte and compares it field by field with what comes out.
// ----------------------------------------------------------------------------

module deframer_result_checker import nmd_pkg::*; #(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       message_end,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] data_byte,
	input  logic       field_select,
	input  logic       has_data,
	input  logic       field_end,
	input  logic       truncated,
	input  logic       format_error,
	output int         fail_count,
	output int         pending
);

	typedef enum logic [2:0] {
		CMD_LEN,
		CMD_BODY,
		SEPARATOR,
		PAY_LEN,
		PAY_BODY,
		TRAILER,
		DISCARD
	} parse_phase_t;

	parse_phase_t            phase;
	logic [LENGTH_BITS-1:0]  length_acc;
	logic [LENGTH_BITS-1:0]  bytes_left;
	bit                      digit_seen;
	result_t                 expected_words[$];
	int                      fails;

	task automatic clear_parser();
		phase = CMD_LEN;
		length_acc = '0;
		bytes_left = '0;
		digit_seen = 1'b0;
	endtask

	// Advance the parser by one byte; hit says whether a result word follows.
	task automatic decode_byte(input logic [7:0] b, input logic last,
			output bit hit, output result_t r);
		logic              fld;
		bit                bad;
		bit                done;
		longint unsigned   digit;
		longint unsigned   len;
		longint unsigned   max_len;
		hit = 1'b0;
		r = '0;
		bad = 1'b0;
		max_len = (64'd1 << LENGTH_BITS) - 1;
		case (phase)
			CMD_LEN, PAY_LEN: begin
				fld = (phase == PAY_LEN) ? FIELD_PAYLOAD : FIELD_COMMAND;
				if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
					digit = 64'(b - DIGIT_ZERO);
					if (longint'(length_acc) > (max_len - digit) / 10) begin
						bad = 1'b1;
					end else begin
						length_acc = LENGTH_BITS'(length_acc * 10 + digit);
						digit_seen = 1'b1;
						if (last)
							bad = 1'b1;
					end
				end else if (b == COLON_CHAR && digit_seen) begin
					len = 64'(length_acc);
					length_acc = '0;
					digit_seen = 1'b0;
					if (fld == FIELD_COMMAND) begin
						if (last) begin
							// payload field is missing
							hit = 1'b1;
							r.field_select = FIELD_PAYLOAD;
							r.format_error = 1'b1;
						end else if (len == 0) begin
							hit = 1'b1;
							r.field_select = FIELD_COMMAND;
							r.field_end = 1'b1;
							phase = SEPARATOR;
						end else begin
							bytes_left = LENGTH_BITS'(len);
							phase = CMD_BODY;
						end
					end else begin
						if (len == 0 || last) begin
							hit = 1'b1;
							r.field_select = FIELD_PAYLOAD;
							r.field_end = 1'b1;
							r.truncated = (len != 0);
							phase = TRAILER;
						end else begin
							bytes_left = LENGTH_BITS'(len);
							phase = PAY_BODY;
						end
					end
				end else begin
					bad = 1'b1;
				end
				if (bad) begin
					hit = 1'b1;
					r = '0;
					r.field_select = fld;
					r.format_error = 1'b1;
					length_acc = '0;
					digit_seen = 1'b0;
					phase = DISCARD;
				end
			end
			CMD_BODY, PAY_BODY: begin
				fld = (phase == PAY_BODY) ? FIELD_PAYLOAD : FIELD_COMMAND;
				if (bytes_left != 0)
					bytes_left = bytes_left - 1'b1;
				done = (bytes_left == 0);
				hit = 1'b1;
				r.data_byte = b;
				r.field_select = fld;
				r.has_data = 1'b1;
				r.field_end = done || last;
				r.truncated = last && !done;
				r.format_error = last && (fld == FIELD_COMMAND);
				if (done)
					phase = (fld == FIELD_COMMAND) ? SEPARATOR : TRAILER;
			end
			SEPARATOR: begin
				if (last) begin
					hit = 1'b1;
					r.field_select = FIELD_PAYLOAD;
					r.format_error = 1'b1;
				end
				phase = PAY_LEN;
			end
			default: begin
			end
		endcase
		if (last)
			clear_parser();
	endtask

	task automatic compare_field(input string name, input int unsigned exp_val,
			input int unsigned got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got_val);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit      hit;
		result_t predicted;
		result_t oldest;
		if (!arst_n) begin
			clear_parser();
			expected_words.delete();
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("result word with no expected result pending");
					fails++;
				end else begin
					oldest = expected_words.pop_front();
					compare_field("data_byte", oldest.data_byte, data_byte);
					compare_field("field_select", oldest.field_select, field_select);
					compare_field("has_data", oldest.has_data, has_data);
					compare_field("field_end", oldest.field_end, field_end);
					compare_field("truncated", oldest.truncated, truncated);
					compare_field("format_error", oldest.format_error, format_error);
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(in_byte, message_end, hit, predicted);
				if (hit)
					expected_words.push_back(predicted);
			end
			fail_count <= fails;
			pending <= expected_words.size();
		end
	end

endmodule

[verif/netstring_message_deframer_unit_tb.sv]
// ----------------------------------------------------------------------------
// Netstring message deframer testbench
// Sends directed and random framed messages, well-formed and broken, with
// random idle and stall bursts; the result checker predicts and compares.
// ----------------------------------------------------------------------------

module netstring_message_deframer_unit_tb import nmd_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_WORDS = 400;
	localparam int QUIET_AFTER = 330;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       message_end;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] data_byte;
	logic       field_select;
	logic       has_data;
	logic       field_end;
	logic       truncated;
	logic       format_error;
	int         fail_count;
	int         pending;

	logic [7:0] frame[$];
	bit         idle_on;
	int         words_sent;
	int         quiet_cycles;

	netstring_message_deframer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.message_end(message_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.field_select(field_select),
		.has_data(has_data),
		.field_end(field_end),
		.truncated(truncated),
		.format_error(format_error)
	);

	deframer_result_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.message_end(message_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.field_select(field_select),
		.has_data(has_data),
		.field_end(field_end),
		.truncated(truncated),
		.format_error(format_error),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// End the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("netstring_message_deframer_unit_tb failed");
				$finish;
			end
		end
	end

	// Receiver stall bursts.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n && idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input logic [7:0] b, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			in_byte <= 8'($urandom);
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		message_end <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_frame();
		foreach (frame[i])
			send_word(frame[i], i == frame.size() - 1);
		frame.delete();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			frame.push_back(s[i]);
	endtask

	// Length digits and colon; big forces an overflow, empty omits the digits.
	task automatic push_length(input int unsigned v, input bit big, input bit empty);
		if (!empty) begin
			if (big)
				v = $urandom_range(65536, 999999);
			if ($urandom_range(0, 5) == 0)
				frame.push_back(DIGIT_ZERO);
			push_text($sformatf("%0d", v));
		end
		frame.push_back(COLON_CHAR);
	endtask

	task automatic build_random_frame();
		int unsigned mode;
		int unsigned which;
		int unsigned cmd_len;
		int unsigned pay_len;
		int unsigned cut;
		// modes 0-5 well-formed, 6 cut short, 7 corrupted byte, 8 overflow, 9 empty length
		mode = $urandom_range(0, 9);
		which = $urandom_range(0, 1);
		cmd_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
		pay_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
		push_length(cmd_len, mode == 8 && which == 0, mode == 9 && which == 0);
		repeat ((mode == 8 && which == 0) ? 3 : cmd_len)
			frame.push_back(8'($urandom));
		frame.push_back(8'($urandom));
		push_length(pay_len, mode == 8 && which == 1, mode == 9 && which == 1);
		repeat (pay_len)
			frame.push_back(8'($urandom));
		repeat ($urandom_range(0, 3))
			frame.push_back(8'($urandom));
		if (mode == 6) begin
			cut = $urandom_range(1, frame.size());
			while (frame.size() > cut)
				void'(frame.pop_back());
		end else if (mode == 7) begin
			frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		message_end = 1'b0;
		idle_on = 1'b1;
		words_sent = 0;
		quiet_cycles = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// normal message with extreme data bytes and a trailer
		push_text("1:");
		frame.push_back(8'h00);
		frame.push_back(8'hFF);
		push_text("1:");
		frame.push_back(8'hFF);
		push_text("z");
		send_frame();
		// both fields empty, message ends on the payload colon
		push_text("0:,0:");
		send_frame();
		// colon with no digits, rest dropped
		push_text(":x");
		send_frame();
		// largest length, message ends inside it
		push_text("65535");
		send_frame();
		// length overflow
		push_text("65536:");
		send_frame();
		// message ends on the command colon
		push_text("1:");
		send_frame();
		// message ends inside the command bytes
		push_text("2:a");
		send_frame();
		// message ends on the separator
		push_text("0:,");
		send_frame();
		// leading zero, message ends on a nonzero payload colon
		push_text("01:c,3:");
		send_frame();
		// payload clipped by the message end
		push_text("1:c,2:p");
		send_frame();

		while (words_sent < RANDOM_WORDS) begin
			idle_on = (words_sent < QUIET_AFTER) && ($urandom_range(0, 5) != 0);
			build_random_frame();
			send_frame();
		end
		idle_on = 1'b0;
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("netstring_message_deframer_unit_tb passed");
		else
			$display("netstring_message_deframer_unit_tb failed");
		$finish;
	end

endmodule

[sim.f]
hdl/nmd_pkg.sv
hdl/nmd_in_reg.sv
hdl/nmd_parser.sv
hdl/nmd_out_reg.sv
hdl/netstring_message_deframer_unit.sv
verif/deframer_result_checker.sv
verif/netstring_message_deframer_unit_tb.sv
